// ===== hw/rtl/csv_field_splitter_core_macros.svh =====
// Assertion helpers for the field splitter. Each samples on clk and stays
// quiet while arst_n is low.
`ifndef CSV_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication.
`define CSVFS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("field splitter check failed");

// Next-cycle implication.
`define CSVFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("field splitter check failed");

`endif

// ===== hw/rtl/csvfs_pkg.sv =====
`default_nettype none
package csvfs_pkg;

	localparam int POS_WIDTH = 32;
	localparam int COL_WIDTH = 16;

	localparam int FIELD_W  = 32;
	localparam int COLF_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 8;

	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
	localparam logic [COL_WIDTH-1:0] COL_MAX = {COL_WIDTH{1'b1}};

	localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

	localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
	localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHAR = 8'd1;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_UNQ,
		MODE_QUO,
		MODE_QSEEN,
		MODE_CLOSED
	} csvfs_mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_input;
	} csvfs_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field_offset;
		logic [FIELD_W-1:0] field_length;
		logic [FIELD_W-1:0] row_number;
		logic [COLF_W-1:0]  column_number;
		logic               row_end;
		logic               last_result;
	} csvfs_out_t;

	typedef struct packed {
		csvfs_mode_t          mode;
		logic                 cr_pending;
		logic [POS_WIDTH-1:0] byte_position;
		logic [POS_WIDTH-1:0] start_offset;
		logic [POS_WIDTH-1:0] held_length;
		logic [POS_WIDTH-1:0] row_count;
		logic [COL_WIDTH-1:0] column_count;
	} csvfs_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             room_for_two;
	} csvfs_fifo_status_t;

	function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [POS_WIDTH-1:0] span(input logic [POS_WIDTH-1:0] e,
		input logic [POS_WIDTH-1:0] b);
		return (e > b) ? e - b : '0;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/csvfs_step.sv =====
`default_nettype none
// Per-byte decision: next scan state and up to two field records.
module csvfs_step (
	input  wire csvfs_pkg::csvfs_state_t cur,
	input  wire csvfs_pkg::csvfs_in_t    item,
	input  wire logic [7:0]              delimiter,
	input  wire logic [7:0]              quote_char,
	output csvfs_pkg::csvfs_state_t      nxt,
	output logic                         r0_valid,
	output csvfs_pkg::csvfs_out_t        r0,
	output logic                         r1_valid,
	output csvfs_pkg::csvfs_out_t        r1
);
	import csvfs_pkg::*;

	always_comb begin
		csvfs_state_t         s;
		logic                 done;
		logic                 ended;
		logic [POS_WIDTH-1:0] pos;
		logic [POS_WIDTH-1:0] pos_inc;
		logic [POS_WIDTH-1:0] len0;
		logic [POS_WIDTH-1:0] len1;
		logic [BYTE_W-1:0]    b;

		s        = cur;
		b        = item.data_byte;
		pos      = cur.byte_position;
		pos_inc  = sat_inc(pos);
		done     = 1'b0;
		ended    = 1'b0;
		len0     = '0;
		len1     = '0;
		r0_valid = 1'b0;
		r1_valid = 1'b0;

		// resolve a deferred CR first
		if (cur.cr_pending) begin
			s.cr_pending = 1'b0;
			if (b == LF_BYTE) begin
				r0_valid       = 1'b1;
				len0           = cur.held_length;
				s.row_count    = sat_inc(cur.row_count);
				s.column_count = '0;
				s.start_offset = pos_inc;
				s.mode         = MODE_UNQ;
				ended          = 1'b1;
				done           = 1'b1;
			end
		end

		// quote seen inside quotes: doubled quote or a close
		if (!done && s.mode == MODE_QSEEN) begin
			if (b == quote_char) begin
				s.mode = MODE_QUO;
				done   = 1'b1;
			end else begin
				s.mode = MODE_CLOSED;
			end
		end

		if (!done) begin
			unique case (s.mode)
				MODE_UNQ: begin
					priority if (b == quote_char) begin
						s.mode         = MODE_QUO;
						s.start_offset = pos_inc;
					end else if (b == delimiter) begin
						r0_valid       = 1'b1;
						len0           = span(pos, cur.start_offset);
						s.column_count = (s.column_count == COL_MAX) ?
							s.column_count : s.column_count + 1'b1;
						s.start_offset = pos_inc;
						s.mode         = MODE_UNQ;
					end else if (b == LF_BYTE) begin
						r0_valid       = 1'b1;
						len0           = span(pos, cur.start_offset);
						s.row_count    = sat_inc(s.row_count);
						s.column_count = '0;
						s.start_offset = pos_inc;
						s.mode         = MODE_UNQ;
						ended          = 1'b1;
					end else if (b == CR_BYTE) begin
						s.held_length = span(pos, s.start_offset);
						s.cr_pending  = 1'b1;
					end else begin
						s.mode = MODE_UNQ;
					end
				end
				MODE_QUO: begin
					if (b == quote_char) begin
						s.held_length = span(pos, s.start_offset);
						s.mode        = MODE_QSEEN;
					end
				end
				default: begin
					// closed quoted field: drop everything up to a terminator
					priority if (b == quote_char) begin
						s.mode = MODE_CLOSED;
					end else if (b == delimiter) begin
						r0_valid       = 1'b1;
						len0           = s.held_length;
						s.column_count = (s.column_count == COL_MAX) ?
							s.column_count : s.column_count + 1'b1;
						s.start_offset = pos_inc;
						s.mode         = MODE_UNQ;
					end else if (b == LF_BYTE) begin
						r0_valid       = 1'b1;
						len0           = s.held_length;
						s.row_count    = sat_inc(s.row_count);
						s.column_count = '0;
						s.start_offset = pos_inc;
						s.mode         = MODE_UNQ;
						ended          = 1'b1;
					end else if (b == CR_BYTE) begin
						s.cr_pending = 1'b1;
					end else begin
						s.mode = MODE_CLOSED;
					end
				end
			endcase
		end

		s.byte_position = pos_inc;

		// records take the state as it stood when each was emitted
		r0.field_offset  = FIELD_W'(cur.start_offset);
		r0.field_length  = FIELD_W'(len0);
		r0.row_number    = FIELD_W'(cur.row_count);
		r0.column_number = COLF_W'(cur.column_count);
		r0.row_end       = ended;
		r0.last_result   = 1'b1;

		if (s.mode == MODE_UNQ || s.mode == MODE_QUO) begin
			len1 = span(pos_inc, s.start_offset);
		end else begin
			len1 = s.held_length;
		end
		r1.field_offset  = FIELD_W'(s.start_offset);
		r1.field_length  = FIELD_W'(len1);
		r1.row_number    = FIELD_W'(s.row_count);
		r1.column_number = COLF_W'(s.column_count);
		r1.row_end       = 1'b1;
		r1.last_result   = 1'b1;

		if (item.end_of_input) begin
			r1_valid       = !ended;
			s.mode         = MODE_UNQ;
			s.cr_pending   = 1'b0;
			s.byte_position = '0;
			s.start_offset = '0;
			s.held_length  = '0;
			s.row_count    = POS_WIDTH'(1);
			s.column_count = '0;
		end

		if (r1_valid) begin
			r0.last_result = 1'b0;
		end

		nxt = s;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/csvfs_fifo.sv =====
`default_nettype none
// Result queue: takes up to two records a cycle, hands out one.
module csvfs_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push0,
	input  wire csvfs_pkg::csvfs_out_t  data0,
	input  wire logic                   push1,
	input  wire csvfs_pkg::csvfs_out_t  data1,
	input  wire logic                   pop,
	output csvfs_pkg::csvfs_out_t       head,
	output logic                        head_valid,
	output csvfs_pkg::csvfs_fifo_status_t status
);
	import csvfs_pkg::*;

	csvfs_out_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic             has_first;
	logic             has_second;
	csvfs_out_t       first_data;
	logic [CNT_W-1:0] n_push;
	logic             do_pop;

	assign has_first  = push0 | push1;
	assign has_second = push0 & push1;
	assign first_data = push0 ? data0 : data1;
	assign n_push     = has_second ? CNT_W'(2) : (has_first ? CNT_W'(1) : CNT_W'(0));
	assign do_pop     = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (has_first) begin
			mem_q[wr_ptr_q] <= first_data;
		end
		if (has_second) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - CNT_W'(do_pop);
		end
	end

	assign head              = mem_q[rd_ptr_q];
	assign head_valid        = (count_q != '0);
	assign status.count      = count_q;
	assign status.room_for_two = (count_q <= CNT_W'(FIFO_DEPTH - 2));

endmodule
`default_nettype wire

// ===== hw/rtl/csv_field_splitter_core.sv =====
`default_nettype none
// CSV field splitter. Bytes of a text arrive on in_data, one per transfer,
// with end_of_input marking the last byte; each field comes out on out_data
// as start offset, content length, row, column and a row-end flag, and
// last_result marks the final record a byte causes (a byte causes zero, one
// or two). Quotes open quoted mode even mid-field, doubled quotes stay raw,
// LF and CRLF end rows, a lone CR is content, and bytes after a closing
// quote are dropped up to the terminator. Rate: one byte per clock cycle
// while in_ready is high. A byte is held in the input register and decided
// there in a single pass; its records then enter a four-entry result queue
// whose head drives the output, so a record is visible once the queue has
// registered it and is taken at a rising edge where out_ready is high. The
// output drains one record per cycle while out_ready is high; in_ready drops
// only while the queue holds more than two records, which happens when the
// sink stalls or bytes emit records faster than one per cycle on average.
// Write delimiter (index 0) and quote_char (index 1) only while idle;
// writes to other indexes are ignored. cfg_ready is always high.
module csv_field_splitter_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire csvfs_pkg::csvfs_in_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output csvfs_pkg::csvfs_out_t      out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [7:0]            cfg_index,
	input  wire logic [7:0]            cfg_data
);
	import csvfs_pkg::*;

	`include "csv_field_splitter_core_macros.svh"

	// configuration registers
	logic [BYTE_W-1:0] delimiter_q;
	logic [BYTE_W-1:0] quote_char_q;

	// input register
	logic       valid_s1;
	csvfs_in_t  item_s1;
	logic       adv_s1;

	// scan state
	csvfs_state_t state_q;
	csvfs_state_t state_nxt;

	logic       r0_valid;
	logic       r1_valid;
	csvfs_out_t r0;
	csvfs_out_t r1;

	csvfs_fifo_status_t fifo_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q  <= DELIM_RESET;
			quote_char_q <= QUOTE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELIMITER:  delimiter_q  <= cfg_data;
				REG_QUOTE_CHAR: quote_char_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the held byte once the queue can absorb both possible records
	assign adv_s1   = valid_s1 && fifo_status.room_for_two;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	csvfs_step u_step (
		.cur        (state_q),
		.item       (item_s1),
		.delimiter  (delimiter_q),
		.quote_char (quote_char_q),
		.nxt        (state_nxt),
		.r0_valid   (r0_valid),
		.r0         (r0),
		.r1_valid   (r1_valid),
		.r1         (r1)
	);

	// commit the scan state only when the byte's records are queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_UNQ;
			state_q.cr_pending    <= 1'b0;
			state_q.byte_position <= '0;
			state_q.start_offset  <= '0;
			state_q.held_length   <= '0;
			state_q.row_count     <= POS_WIDTH'(1);
			state_q.column_count  <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	csvfs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push0      (adv_s1 && r0_valid),
		.data0      (r0),
		.push1      (adv_s1 && r1_valid),
		.data1      (r1),
		.pop        (out_ready),
		.head       (out_data),
		.head_valid (out_valid),
		.status     (fifo_status)
	);

	// queue never overfills
	`CSVFS_ASSERT_IMPL(a_fifo_bound, 1'b1, fifo_status.count <= CNT_W'(FIFO_DEPTH))
	// a held byte that cannot advance stays held
	`CSVFS_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1)
	// a stalled record is not lost
	`CSVFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// row numbers are one-based
	`CSVFS_ASSERT_IMPL(a_row_nonzero, 1'b1, state_q.row_count != '0)

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import csvfs_pkg::*;

	// Cycles without any transfer on any channel before the run is called hung.
	localparam int QUIET_LIMIT = 5000;
	// Length of the deliberate sink hold-off used to back the block up.
	localparam int HOLD_CYCLES = 300;
	// Items of random text for each register setting.
	localparam int ITEMS_PER_SETTING = 180;
	// Writes below this index are real registers; at or above it they are ignored.
	localparam logic [7:0] REG_FIRST_UNUSED = REG_QUOTE_CHAR + 8'd1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	csvfs_in_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	csvfs_out_t out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	csv_field_splitter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Field predictor: a private copy of the tokenizer state and registers.
	// ------------------------------------------------------------------
	logic [7:0]           cur_delim = DELIM_RESET;
	logic [7:0]           cur_quote = QUOTE_RESET;
	csvfs_mode_t          sc_mode = MODE_UNQ;
	bit                   sc_cr_wait = 1'b0;
	logic [POS_WIDTH-1:0] sc_pos = '0;
	logic [POS_WIDTH-1:0] sc_start = '0;
	logic [POS_WIDTH-1:0] sc_held = '0;
	logic [POS_WIDTH-1:0] sc_row = 1;
	logic [COL_WIDTH-1:0] sc_col = '0;

	csvfs_out_t byte_fields[$];     // fields caused by the byte being predicted
	csvfs_out_t pending_fields[$];  // fields still owed by the block, oldest first

	logic [7:0] text_bytes[$];      // text under construction

	int mismatch_count = 0;
	int fields_seen = 0;
	int quiet_cycles = 0;

	// Traffic shaping, in percent per cycle.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	// Sink hold-off request: bump hold_tag to start one hold of HOLD_CYCLES.
	int hold_tag = 0;
	int hold_seen = 0;
	int hold_left = 0;

	function automatic logic [POS_WIDTH-1:0] bump(input logic [POS_WIDTH-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [POS_WIDTH-1:0] gap_len(input logic [POS_WIDTH-1:0] stop,
		input logic [POS_WIDTH-1:0] from);
		return (stop > from) ? stop - from : '0;
	endfunction

	function automatic void emit_field(input logic [POS_WIDTH-1:0] len, input bit rend);
		csvfs_out_t f;
		f.field_offset  = sc_start;
		f.field_length  = len;
		f.row_number    = sc_row;
		f.column_number = sc_col;
		f.row_end       = rend;
		f.last_result   = 1'b0;
		byte_fields.insert(byte_fields.size(), f);
	endfunction

	// Advance to the next field of the same row.
	function automatic void close_field(input logic [POS_WIDTH-1:0] p);
		if (sc_col != COL_MAX)
			sc_col = sc_col + 1'b1;
		sc_start = bump(p);
		sc_mode = MODE_UNQ;
	endfunction

	// Advance to the first field of the next row.
	function automatic void close_row(input logic [POS_WIDTH-1:0] p);
		sc_row = bump(sc_row);
		sc_col = '0;
		sc_start = bump(p);
		sc_mode = MODE_UNQ;
	endfunction

	function automatic void clear_scan();
		sc_mode = MODE_UNQ;
		sc_cr_wait = 1'b0;
		sc_pos = '0;
		sc_start = '0;
		sc_held = '0;
		sc_row = 1;
		sc_col = '0;
	endfunction

	// Work out the fields one accepted byte causes and queue them as owed.
	function automatic void split_byte(input logic [7:0] b, input logic eoi);
		logic [POS_WIDTH-1:0] p;
		bit ended;
		bit done;
		p = sc_pos;
		ended = 1'b0;
		done = 1'b0;
		byte_fields.delete();

		// A CR held back from the previous byte: LF completes the row end.
		if (sc_cr_wait) begin
			sc_cr_wait = 1'b0;
			if (b == LF_BYTE) begin
				emit_field(sc_held, 1'b1);
				close_row(p);
				ended = 1'b1;
				done = 1'b1;
			end
		end

		// A quote seen inside quotes: a second quote keeps it raw, else it closed.
		if (!done && sc_mode == MODE_QSEEN) begin
			if (b == cur_quote) begin
				sc_mode = MODE_QUO;
				done = 1'b1;
			end else begin
				sc_mode = MODE_CLOSED;
			end
		end

		if (!done) begin
			case (sc_mode)
				MODE_UNQ: begin
					if (b == cur_quote) begin
						sc_mode = MODE_QUO;
						sc_start = bump(p);
					end else if (b == cur_delim) begin
						emit_field(gap_len(p, sc_start), 1'b0);
						close_field(p);
					end else if (b == LF_BYTE) begin
						emit_field(gap_len(p, sc_start), 1'b1);
						close_row(p);
						ended = 1'b1;
					end else if (b == CR_BYTE) begin
						sc_held = gap_len(p, sc_start);
						sc_cr_wait = 1'b1;
					end
				end
				MODE_QUO: begin
					if (b == cur_quote) begin
						sc_held = gap_len(p, sc_start);
						sc_mode = MODE_QSEEN;
					end
				end
				default: begin
					// closed quoted field: drop everything up to a terminator
					if (b == cur_quote) begin
					end else if (b == cur_delim) begin
						emit_field(sc_held, 1'b0);
						close_field(p);
					end else if (b == LF_BYTE) begin
						emit_field(sc_held, 1'b1);
						close_row(p);
						ended = 1'b1;
					end else if (b == CR_BYTE) begin
						sc_cr_wait = 1'b1;
					end
				end
			endcase
		end

		sc_pos = bump(p);

		if (eoi) begin
			if (!ended) begin
				if (sc_mode == MODE_UNQ || sc_mode == MODE_QUO)
					emit_field(gap_len(bump(p), sc_start), 1'b1);
				else
					emit_field(sc_held, 1'b1);
			end
			clear_scan();
		end

		if (byte_fields.size() != 0)
			byte_fields[byte_fields.size()-1].last_result = 1'b1;
		foreach (byte_fields[k])
			pending_fields.insert(pending_fields.size(), byte_fields[k]);
	endfunction

	// ------------------------------------------------------------------
	// Result side: sink ready pattern and field checker.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_tag != hold_seen) begin
			hold_seen <= hold_tag;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			// hold off the sink so the result queue fills and stalls the input
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("mismatch on field %0d, %0s: got %0d, expected %0d",
			fields_seen, what, got, want);
	endtask

	always @(posedge clk) begin : check_fields
		csvfs_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fields.size() == 0) begin
				report_mismatch("field with none owed, offset", out_data.field_offset, 0);
			end else begin
				want = pending_fields.pop_front();
				if (out_data.field_offset !== want.field_offset)
					report_mismatch("field_offset", out_data.field_offset,
						want.field_offset);
				if (out_data.field_length !== want.field_length)
					report_mismatch("field_length", out_data.field_length,
						want.field_length);
				if (out_data.row_number !== want.row_number)
					report_mismatch("row_number", out_data.row_number, want.row_number);
				if (out_data.column_number !== want.column_number)
					report_mismatch("column_number", out_data.column_number,
						want.column_number);
				if (out_data.row_end !== want.row_end)
					report_mismatch("row_end", out_data.row_end, want.row_end);
				if (out_data.last_result !== want.last_result)
					report_mismatch("last_result", out_data.last_result, want.last_result);
			end
			fields_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: count cycles in which nothing transfers anywhere.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Offer one byte, hold it until the transfer, then predict its fields.
	// Valid stays high afterward so the next byte can follow back to back.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		csvfs_in_t item;
		item.data_byte = b;
		item.end_of_input = eoi;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
		split_byte(b, eoi);
	endtask

	// Append one byte to the text under construction.
	function automatic void add_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endfunction

	// Send the text under construction, marking its last byte.
	task automatic send_text();
		for (int k = 0; k < text_bytes.size(); k++)
			send_byte(text_bytes[k], k == text_bytes.size() - 1);
	endtask

	// Pause the input until every owed field has arrived, then let the
	// pipeline settle so bytes that cause no field have also passed.
	task automatic wait_fields_drained();
		in_valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write both registers plus one index past the list; valid stays high
	// across the three transfers and drops once at the end.
	task automatic program_regs(input logic [7:0] delim, input logic [7:0] quote);
		logic [7:0] idx[3];
		logic [7:0] val[3];
		idx[0] = REG_DELIMITER;
		val[0] = delim;
		idx[1] = REG_QUOTE_CHAR;
		val[1] = quote;
		idx[2] = 8'($urandom_range(255, REG_FIRST_UNUSED));
		val[2] = 8'($urandom_range(255));
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (idx[k])
				REG_DELIMITER:  cur_delim = val[k];
				REG_QUOTE_CHAR: cur_quote = val[k];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Any byte that is none of the four special ones under the current setting.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == cur_delim || b == cur_quote || b == LF_BYTE || b == CR_BYTE);
		return b;
	endfunction

	// Mostly well-formed rows with random content; the rest is noise dense in
	// quotes, delimiters and line ends.
	task automatic build_text();
		int rows;
		int cols;
		int len;
		int pick;
		text_bytes.delete();
		if ($urandom_range(99) < 70) begin
			rows = $urandom_range(3, 1);
			for (int r = 0; r < rows; r++) begin
				cols = $urandom_range(4, 1);
				for (int c = 0; c < cols; c++) begin
					if (c != 0)
						add_byte(cur_delim);
					len = $urandom_range(5);
					if ($urandom_range(2) == 0) begin
						add_byte(cur_quote);
						for (int i = 0; i < len; i++) begin
							pick = $urandom_range(9);
							case (pick)
								0: begin
									add_byte(cur_quote);
									add_byte(cur_quote);
								end
								1: add_byte(cur_delim);
								2: add_byte(LF_BYTE);
								3: add_byte(CR_BYTE);
								default: add_byte(plain_byte());
							endcase
						end
						add_byte(cur_quote);
					end else begin
						for (int i = 0; i < len; i++)
							add_byte(plain_byte());
					end
				end
				if (r < rows - 1 || $urandom_range(1) == 1) begin
					if ($urandom_range(1) == 1)
						add_byte(CR_BYTE);
					add_byte(LF_BYTE);
				end
			end
		end else begin
			len = $urandom_range(24, 1);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(11);
				case (pick)
					0, 1, 2: add_byte(cur_quote);
					3, 4:    add_byte(cur_delim);
					5:       add_byte(LF_BYTE);
					6:       add_byte(CR_BYTE);
					7, 8:    add_byte(8'($urandom_range(255)));
					default: add_byte(plain_byte());
				endcase
			end
		end
		if (text_bytes.size() == 0)
			add_byte(plain_byte());
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Hand-picked bytes under the reset setting.
	task automatic test_directed_bytes();
		// NUL content, then a quote mid-field restarts the field
		send_byte(8'h00, 1'b0);
		send_byte(cur_quote, 1'b0);
		send_byte("q", 1'b0);
		// doubled quote stays raw
		send_byte(cur_quote, 1'b0);
		send_byte(cur_quote, 1'b0);
		send_byte("z", 1'b0);
		// closing quote; the junk behind it, another quote too, is dropped
		send_byte(cur_quote, 1'b0);
		send_byte("x", 1'b0);
		send_byte(cur_quote, 1'b0);
		send_byte(cur_delim, 1'b0);
		// 0xFF, a lone CR as content, then CRLF ends the row
		send_byte(8'hFF, 1'b0);
		send_byte(CR_BYTE, 1'b0);
		send_byte("k", 1'b0);
		send_byte(CR_BYTE, 1'b0);
		send_byte(LF_BYTE, 1'b0);
		// unclosed quote at end of input runs to the last byte
		send_byte(cur_quote, 1'b0);
		send_byte("u", 1'b1);
		// trailing delimiter at end of input: two fields from one byte
		send_byte(cur_delim, 1'b1);
		// LF as last byte: the row is already closed
		send_byte("a", 1'b0);
		send_byte(LF_BYTE, 1'b1);
		// CR as last byte is still undecided at end of input
		send_byte(CR_BYTE, 1'b1);
		// closed quoted field ended by CRLF
		send_byte(cur_quote, 1'b0);
		send_byte("a", 1'b0);
		send_byte(cur_quote, 1'b0);
		send_byte(CR_BYTE, 1'b0);
		send_byte(LF_BYTE, 1'b1);
		wait_fields_drained();
	endtask

	// Hold the sink off while bytes keep coming, so the result queue fills
	// and the input stalls; then pause until everything owed has come out.
	task automatic test_input_backpressure();
		src_idle_pct = 0;
		sink_stall_pct <= 0;
		hold_tag <= hold_tag + 1;
		for (int i = 0; i < 40; i++)
			send_byte((i % 5 == 4) ? LF_BYTE : cur_delim, i == 39);
		wait_fields_drained();
	endtask

	// Random texts across the four traffic phases.
	task automatic test_random_texts(input int n_items);
		int sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct = 83;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct <= 83;
				end
				default: begin
					src_idle_pct = 17;
					sink_stall_pct <= 17;
				end
			endcase
			sent = 0;
			while (sent < n_items / 4) begin
				build_text();
				send_text();
				sent += text_bytes.size();
			end
		end
		src_idle_pct = 0;
		sink_stall_pct <= 0;
	endtask

	// Walk the registers through several settings, extremes and collisions
	// among them, with random traffic under each; end on the reset values.
	task automatic test_register_sweep();
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		program_regs(";", "'");
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		program_regs(8'h00, 8'hFF);
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		// delimiter wins over LF, quote over CR
		program_regs(LF_BYTE, CR_BYTE);
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		// delimiter wins over CR, so CRLF no longer ends a row
		program_regs(CR_BYTE, LF_BYTE);
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		// same byte for both: the quote test comes first
		program_regs("|", "|");
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		program_regs(8'hFF, 8'h00);
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
		program_regs(DELIM_RESET, QUOTE_RESET);
		test_random_texts(ITEMS_PER_SETTING);
		wait_fields_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_bytes();
		test_input_backpressure();
		test_register_sweep();

		// settle, then give the verdict
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_fields.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
